### src/adts_frame_splitter_unit_assert.svh
// assertion macros shared by the splitter files
`ifndef ADTS_FRAME_SPLITTER_UNIT_ASSERT_SVH
`define ADTS_FRAME_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define AFS_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define AFS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### src/afs_pkg.sv
package afs_pkg;

    // result status codes
    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_SYNC    = 3'd2;
    localparam logic [2:0] ST_LENGTH  = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    // header constants
    localparam logic [7:0]  SYNC_BYTE0    = 8'hFF;
    localparam logic [7:0]  SYNC1_MASK    = 8'hF6;
    localparam logic [7:0]  SYNC1_VALUE   = 8'hF0;
    localparam logic [12:0] HDR_BYTES     = 13'd7;
    localparam logic [12:0] MIN_LEN_NOCRC = 13'd7;
    localparam logic [12:0] MIN_LEN_CRC   = 13'd9;

    // frame duration after reset, in microseconds
    localparam logic [17:0] DURATION_RESET = 18'd21334;

    // one result item
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic [47:0] frame_time_us;
        logic [12:0] frame_length;
        logic        crc_present;
    } afs_result_t;

endpackage

### src/afs_skid.sv
`include "adts_frame_splitter_unit_assert.svh"

module afs_skid
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 in_ready,
    input  afs_pkg::afs_result_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output afs_pkg::afs_result_t out_data
);

    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    afs_pkg::afs_result_t out_reg;
    afs_pkg::afs_result_t skid_reg;
    logic                 pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // control: output stage and one spare entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                // nothing moves this cycle
            end
        end
    end

    // payload moves without reset
    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= in_data;
            end
            else
            begin
                out_reg <= in_data;
            end
        end
        else
        begin
            // nothing moves this cycle
        end
    end

    `AFS_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "spare entry without output")
    `AFS_ASSERT_NEXT(a_skid_drains_first, skid_valid_reg && pop, out_valid_reg, "output lost on drain")

endmodule

### src/adts_frame_splitter_unit.sv
// channel | dir | tdata fields (low bit up)                        | tuser  | tlast
// s_axis  | in  | data_byte[7:0]                                   | -      | stream_end
// m_axis  | out | payload_byte, frame_time_us, frame_length,       | status | frame_last
//         |     | crc_present, two zero pad bits                   |        |
// cfg     | in  | cfg_wdata = frame duration in us, on cfg_we      | -      | -
//
// one byte accepted per cycle while s_tready is high; each result is built
// combinationally from the parser state and its byte and registered in the output buffer
// s_tready is low only while the two-entry output buffer is full
// rst_n clears the parse position, timestamp, halt flag and buffered results
// after a sync, length or truncation error the block keeps taking bytes and
// drops them until reset
`include "adts_frame_splitter_unit_assert.svh"

module adts_frame_splitter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // payload_byte, frame_time_us, frame_length, crc_present, pad
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast,   // frame_last
    input  logic        cfg_we,
    input  logic [17:0] cfg_wdata
);

    // header byte positions
    localparam logic [12:0] POS_SYNC0   = 13'd0;
    localparam logic [12:0] POS_SYNC1   = 13'd1;
    localparam logic [12:0] POS_BUF     = 13'd2;
    localparam logic [12:0] POS_LEN_HI  = 13'd3;
    localparam logic [12:0] POS_LEN_MID = 13'd4;
    localparam logic [12:0] POS_LEN_LO  = 13'd5;
    localparam logic [12:0] POS_HDR_END = 13'd6;

    logic [17:0] dur_reg;
    logic [12:0] pos_reg, pos_next;
    logic [12:0] len_reg, len_next;
    logic        crc_reg, crc_next;
    logic [47:0] time_reg, time_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic        emit;
    logic        err;
    logic        done;
    logic        last;
    logic [2:0]  status;
    logic [7:0]  pbyte;
    logic [12:0] min_len;

    afs_pkg::afs_result_t res;
    afs_pkg::afs_result_t out_res;

    assign accept  = s_tvalid && s_tready;
    assign min_len = crc_reg ? afs_pkg::MIN_LEN_CRC : afs_pkg::MIN_LEN_NOCRC;

    // per-byte parse step
    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        time_next   = time_reg;
        halted_next = halted_reg;
        emit        = 1'b0;
        err         = 1'b0;
        done        = 1'b0;
        last        = 1'b0;
        status      = afs_pkg::ST_PAYLOAD;
        pbyte       = 8'd0;
        if (accept && !halted_reg)
        begin
            unique case (pos_reg)
                POS_SYNC0:
                begin
                    len_next = 13'd0;
                    crc_next = 1'b0;
                    if (s_tdata != afs_pkg::SYNC_BYTE0)
                    begin
                        err    = 1'b1;
                        status = afs_pkg::ST_SYNC;
                    end
                end
                POS_SYNC1:
                begin
                    if ((s_tdata & afs_pkg::SYNC1_MASK) != afs_pkg::SYNC1_VALUE)
                    begin
                        err    = 1'b1;
                        status = afs_pkg::ST_SYNC;
                    end
                    else
                    begin
                        crc_next = ~s_tdata[0];
                    end
                end
                POS_BUF:
                begin
                end
                POS_LEN_HI:
                begin
                    len_next = {s_tdata[1:0], 11'd0};
                end
                POS_LEN_MID:
                begin
                    len_next = len_reg | {2'd0, s_tdata, 3'd0};
                end
                POS_LEN_LO:
                begin
                    len_next = len_reg | {10'd0, s_tdata[7:5]};
                    if (len_next < min_len)
                    begin
                        err    = 1'b1;
                        status = afs_pkg::ST_LENGTH;
                    end
                end
                POS_HDR_END:
                begin
                    if (len_reg == afs_pkg::HDR_BYTES)
                    begin
                        emit   = 1'b1;
                        status = afs_pkg::ST_EMPTY;
                        last   = 1'b1;
                        done   = 1'b1;
                    end
                end
                default:
                begin
                    emit  = 1'b1;
                    pbyte = s_tdata;
                    last  = (({1'b0, pos_reg} + 14'd1) == {1'b0, len_reg});
                    done  = last;
                end
            endcase

            // error, frame end, or advance with truncation check
            priority if (err)
            begin
                emit        = 1'b1;
                last        = 1'b1;
                halted_next = 1'b1;
            end
            else if (done)
            begin
                time_next = time_reg + {30'd0, dur_reg};
                pos_next  = 13'd0;
            end
            else
            begin
                pos_next = pos_reg + 13'd1;
                if (s_tlast)
                begin
                    emit        = 1'b1;
                    status      = afs_pkg::ST_TRUNC;
                    pbyte       = 8'd0;
                    last        = 1'b1;
                    halted_next = 1'b1;
                end
            end
        end
    end

    // result for the buffer
    always_comb
    begin
        res.status        = status;
        res.payload_byte  = pbyte;
        res.frame_last    = last;
        res.frame_time_us = time_reg;
        res.frame_length  = len_next;
        res.crc_present   = crc_next;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 13'd0;
            len_reg    <= 13'd0;
            crc_reg    <= 1'b0;
            time_reg   <= 48'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            time_reg   <= time_next;
            halted_reg <= halted_next;
        end
    end

    // frame duration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= afs_pkg::DURATION_RESET;
        end
        else if (cfg_we)
        begin
            dur_reg <= cfg_wdata;
        end
    end

    // output buffer
    afs_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // master-side packing
    assign m_tdata = {2'b00, out_res.crc_present, out_res.frame_length,
                      out_res.frame_time_us, out_res.payload_byte};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.frame_last;

    `AFS_ASSERT_NEXT(a_halt_sticks, halted_reg, halted_reg, "halt flag cleared without reset")
    `AFS_ASSERT_IMP(a_no_result_when_halted, halted_reg, !emit, "result while halted")
    `AFS_ASSERT_IMP(a_pos_in_frame, pos_reg > POS_HDR_END, pos_reg < len_reg, "position past frame")
    `AFS_ASSERT_NEXT(a_error_halts, accept && emit && (status == afs_pkg::ST_SYNC ||
                     status == afs_pkg::ST_LENGTH || status == afs_pkg::ST_TRUNC),
                     halted_reg, "error without halt")

endmodule
